@@ src/twdpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// twdpt_pkg
// Shared types and codes for the two-way depth-preferred lookup table: request
// and response payloads, the bucket word held in memory, and command codes.
// ----------------------------------------------------------------------------
package twdpt_pkg;

	localparam int WAYS      = 2;
	localparam int HASH_W    = 12;
	localparam int KEY_W     = 64;
	localparam int COUNT_W   = 14;
	localparam int CFG_IDX_W = 1;

	// Command codes
	localparam logic [1:0] CMD_STORE = 2'd0;
	localparam logic [1:0] CMD_PROBE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Bound kinds
	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_UPPER = 2'd2;
	localparam logic [1:0] BOUND_ALT   = 2'd3;

	// Move code recorded when no best move is stored
	localparam logic [7:0] NO_MOVE = 8'hFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_WAY    = 1'd1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [KEY_W-1:0]  position_key;
		logic [HASH_W-1:0] bucket_hash;
		logic signed [15:0] new_score;
		logic signed [15:0] new_depth;
		logic [1:0]        new_bound;
		logic              new_move_valid;
		logic [7:0]        new_move_index;
	} req_t;

	typedef struct packed {
		logic               success;
		logic signed [15:0] found_score;
		logic [7:0]         found_depth;
		logic [1:0]         found_bound;
		logic               found_move_valid;
		logic [7:0]         found_move_index;
		logic [COUNT_W-1:0] occupied_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [15:0]      score;
		logic [7:0]       depth;
		logic [1:0]       bound;
		logic [7:0]       move;
	} way_t;

	typedef struct packed {
		logic                  toggle;
		logic [WAYS-1:0]       valid;
		way_t [WAYS-1:0]       way;
	} bucket_t;

	typedef enum logic [1:0] {
		S_SWEEP = 2'd0,
		S_IDLE  = 2'd1,
		S_EXEC  = 2'd2
	} state_t;

endpackage
`default_nettype wire

@@ src/two_way_depth_preferred_table.sv @@
`default_nettype none
// Response: an accepted request's bucket is read into the execute state, and its
//   response is registered once the response register has room (not stalled).
// Requests: a new request is taken only in the idle state, after the bucket
//   memory read and the write-back of the modified bucket for the previous one.
// Reset: a clearing pass over the BUCKETS buckets (4096 by default) empties them,
//   stalling requests; every clear request runs the same pass after its response.
// ----------------------------------------------------------------------------
// two_way_depth_preferred_table
// Two-way set-associative table of position entries. Store keeps the deeper,
// or the exact, entry; probe returns the matching entry. All bucket state sits
// in one synchronous memory, one bucket word per address.
// ----------------------------------------------------------------------------
module two_way_depth_preferred_table #(
	parameter int BUCKETS = 4096,
	parameter int CELLS   = 121
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// request channel
	input  wire                                  req_valid,
	output logic                                 req_stall,
	input  twdpt_pkg::req_t                      req_data,
	// response channel
	output logic                                 rsp_valid,
	input  wire                                  rsp_stall,
	output twdpt_pkg::rsp_t                      rsp_data,
	// configuration write channel
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [twdpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire                                  cfg_data
);
	import twdpt_pkg::*;

	localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int EXT_W = (IDX_W > HASH_W) ? IDX_W : HASH_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUCKETS - 1);
	localparam logic [7:0]       CELL_LIM = 8'(CELLS);

	// Bucket memory: valid bits, victim toggle and both ways per address
	bucket_t mem [BUCKETS];

	state_t state_q, state_d;

	logic             table_enabled_q;
	logic             single_way_q;
	logic [IDX_W-1:0] sweep_q;
	logic [COUNT_W-1:0] count_q;

	logic             req_fire;
	logic [EXT_W-1:0] hash_ext;
	logic [IDX_W-1:0] rd_addr;

	req_t             req_s1;
	logic [IDX_W-1:0] bkt_s1;
	bucket_t          rd_s1;

	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             out_free;
	logic             rsp_load;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	bucket_t          mem_wdata;
	logic             sweep_start;

	// datapath of the execute step
	logic [7:0]       depth_c;
	logic [1:0]       bound_c;
	logic [7:0]       move_c;
	way_t             new_way;
	logic [WAYS-1:0]  way_mask;
	logic [WAYS-1:0]  eff_valid;
	logic [WAYS-1:0]  match;
	logic [WAYS-1:0]  blocked;
	logic [WAYS-1:0]  elig;
	logic             victim;
	bucket_t          upd;
	logic             st_ok;
	logic             cnt_inc;
	logic             store_go;
	logic             probe_hit;
	way_t             hit_way;
	logic [COUNT_W-1:0] count_d;
	rsp_t             rsp_d;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign req_fire = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Bucket select: single-way mode pins everything to bucket zero
	assign hash_ext = EXT_W'(req_data.bucket_hash);
	assign rd_addr  = single_way_q ? '0 : (hash_ext[IDX_W-1:0] & IDX_LAST);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_enabled_q <= 1'b1;
			single_way_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_ENABLED: table_enabled_q <= cfg_data;
				CFG_SINGLE_WAY:    single_way_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rd_s1  <= mem[rd_addr];
			bkt_s1 <= rd_addr;
			req_s1 <= req_data;
		end
	end

	// Execute step: decode the request against the bucket just read
	always_comb begin
		// clamp depth to 0..255
		if (req_s1.new_depth[15]) begin
			depth_c = 8'd0;
		end else if (req_s1.new_depth[14:8] != '0) begin
			depth_c = 8'hFF;
		end else begin
			depth_c = req_s1.new_depth[7:0];
		end
		bound_c = (req_s1.new_bound == BOUND_ALT) ? BOUND_UPPER : req_s1.new_bound;
		move_c  = (req_s1.new_move_valid && (req_s1.new_move_index < CELL_LIM)) ?
			req_s1.new_move_index : NO_MOVE;
		new_way = '{key: req_s1.position_key, score: req_s1.new_score,
			depth: depth_c, bound: bound_c, move: move_c};

		way_mask  = single_way_q ? 2'b01 : 2'b11;
		eff_valid = rd_s1.valid & way_mask;
		for (int w = 0; w < WAYS; w++) begin
			match[w]   = eff_valid[w] && (rd_s1.way[w].key == req_s1.position_key);
			blocked[w] = (rd_s1.way[w].depth > depth_c) ||
				((rd_s1.way[w].depth == depth_c) && (rd_s1.way[w].bound == BOUND_EXACT) &&
				(bound_c != BOUND_EXACT));
		end
		elig = ~blocked & way_mask;

		// victim choice when both ways may go: shallower, else non-exact, else toggle
		if (rd_s1.way[0].depth != rd_s1.way[1].depth) begin
			victim = rd_s1.way[0].depth < rd_s1.way[1].depth ? 1'b0 : 1'b1;
		end else if ((rd_s1.way[0].bound != rd_s1.way[1].bound) &&
				((rd_s1.way[0].bound == BOUND_EXACT) ||
				(rd_s1.way[1].bound == BOUND_EXACT))) begin
			victim = (rd_s1.way[0].bound == BOUND_EXACT) ? 1'b1 : 1'b0;
		end else begin
			victim = rd_s1.toggle;
		end

		upd     = rd_s1;
		st_ok   = 1'b0;
		cnt_inc = 1'b0;
		if (match[0]) begin
			if (!blocked[0]) begin
				upd.way[0] = new_way;
				st_ok      = 1'b1;
			end
		end else if (match[1]) begin
			if (!blocked[1]) begin
				upd.way[1] = new_way;
				st_ok      = 1'b1;
			end
		end else if (!eff_valid[0]) begin
			upd.way[0]   = new_way;
			upd.valid[0] = 1'b1;
			st_ok        = 1'b1;
			cnt_inc      = 1'b1;
		end else if (way_mask[1] && !eff_valid[1]) begin
			upd.way[1]   = new_way;
			upd.valid[1] = 1'b1;
			st_ok        = 1'b1;
			cnt_inc      = 1'b1;
		end else if (elig[0] && elig[1]) begin
			upd.way[victim] = new_way;
			st_ok           = 1'b1;
			if (rd_s1.way[0].depth == rd_s1.way[1].depth &&
					!((rd_s1.way[0].bound != rd_s1.way[1].bound) &&
					((rd_s1.way[0].bound == BOUND_EXACT) ||
					(rd_s1.way[1].bound == BOUND_EXACT)))) begin
				upd.toggle = ~rd_s1.toggle;
			end
		end else if (elig[0]) begin
			upd.way[0] = new_way;
			st_ok      = 1'b1;
		end else if (elig[1]) begin
			upd.way[1] = new_way;
			st_ok      = 1'b1;
		end

		store_go  = table_enabled_q && (req_s1.cmd == CMD_STORE) && st_ok;
		probe_hit = table_enabled_q && (req_s1.cmd == CMD_PROBE) && (match != '0);
		hit_way   = match[0] ? rd_s1.way[0] : rd_s1.way[1];

		// next occupied count
		if (req_s1.cmd == CMD_CLEAR) begin
			count_d = '0;
		end else if (store_go && cnt_inc) begin
			count_d = count_q + COUNT_W'(1);
		end else begin
			count_d = count_q;
		end

		rsp_d                = '0;
		rsp_d.occupied_count = count_d;
		case (req_s1.cmd)
			CMD_STORE: rsp_d.success = store_go;
			CMD_PROBE: begin
				if (probe_hit) begin
					rsp_d.success     = 1'b1;
					rsp_d.found_score = hit_way.score;
					rsp_d.found_depth = hit_way.depth;
					rsp_d.found_bound = hit_way.bound;
					if (hit_way.move < CELL_LIM) begin
						rsp_d.found_move_valid = 1'b1;
						rsp_d.found_move_index = hit_way.move;
					end
				end
			end
			CMD_CLEAR: rsp_d.success = 1'b1;
			default: ;
		endcase
	end

	// Sequencer: sweep, wait for a request, read-modify-write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_stall   = 1'b1;
		mem_we      = 1'b0;
		mem_waddr   = bkt_s1;
		mem_wdata   = upd;
		rsp_load    = 1'b0;
		sweep_start = 1'b0;
		case (state_q)
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
				if (sweep_q == IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the response register has room
				if (out_free) begin
					rsp_load = 1'b1;
					mem_we   = store_go;
					if (req_s1.cmd == CMD_CLEAR) begin
						sweep_start = 1'b1;
						state_d     = S_SWEEP;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_SWEEP;
		endcase
	end

	// Sweep counter and occupied count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			count_q <= '0;
		end else begin
			if (sweep_start) begin
				sweep_q <= '0;
			end else if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
			if (rsp_load) begin
				count_q <= count_d;
			end
		end
	end

	// Response register: advance when taken, load on execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// Checks
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> req_stall)
		else $error("request taken during clearing pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= 2 * BUCKETS)
		else $error("occupied count beyond table capacity");

	a_clear_zeroes_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && (req_s1.cmd == CMD_CLEAR)) |=> (count_q == '0) && (state_q == S_SWEEP))
		else $error("clear request did not reset count and start sweep");

	a_write_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == S_SWEEP) || (state_q == S_EXEC)))
		else $error("bucket memory written outside sweep or execute");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && (req_s1.cmd != CMD_CLEAR)) |=>
			((count_q == $past(count_q)) || (count_q == $past(count_q) + COUNT_W'(1))))
		else $error("occupied count moved by more than one");

endmodule
`default_nettype wire

@@ tb/tb_two_way_depth_preferred_table.sv @@
// ----------------------------------------------------------------------------
// tb_two_way_depth_preferred_table
// Self-checking bench for the two-way depth-preferred position table. A mirror
// of the bucket array in the bench predicts the reply to every accepted request.
// Each reply taken from the block is checked field by field against the oldest
// prediction. Requests start with hand-picked cases and then become random
// traffic over a small pool of colliding keys. The bench runs in both way
// modes, with the table disabled, and with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_two_way_depth_preferred_table;
	import twdpt_pkg::*;

	localparam int BUCKETS = 4096;
	localparam int CELLS   = 121;
	localparam int POOL    = 16;

	// Codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [1:0] BOUND_LOWER = 2'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;

	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic cfg_data = 1'b0;

	// Idling controls shared by the request and reply sides
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int unsigned rx_hold_cycles = 0;

	// Replies still owed by the block, oldest first
	rsp_t replies_due [$];
	int unsigned mismatch_count = 0;

	// Mirror of the table contents and of the two registers
	bit [WAYS-1:0] mirror_valid [BUCKETS];
	bit mirror_toggle [BUCKETS];
	way_t mirror_way [BUCKETS*WAYS];
	int unsigned mirror_count = 0;
	bit mirror_enabled = 1'b1;
	bit mirror_single = 1'b0;

	// Keys that collide in a handful of buckets, so that stores meet each other
	logic [KEY_W-1:0] pool_key [POOL];
	logic [HASH_W-1:0] pool_hash [POOL];

	two_way_depth_preferred_table #(
		.BUCKETS(BUCKETS),
		.CELLS(CELLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// A way may be overwritten when it is no deeper than the incoming entry,
	// and an equally deep exact entry only yields to another exact one.
	function automatic bit evictable(way_t held, way_t fresh);
		return held.depth <= fresh.depth &&
			(held.depth != fresh.depth || held.bound != BOUND_EXACT ||
			fresh.bound == BOUND_EXACT);
	endfunction

	function automatic bit store_entry(int unsigned b, int unsigned ways, req_t r);
		way_t fresh, w0, w1;
		int unsigned w, s, victim;
		bit e0, e1;
		fresh.key = r.position_key;
		fresh.score = r.new_score;
		// Clamp depth: negative to zero, anything above a byte to 255
		if (r.new_depth[15])
			fresh.depth = 8'd0;
		else if (|r.new_depth[14:8])
			fresh.depth = 8'd255;
		else
			fresh.depth = r.new_depth[7:0];
		fresh.bound = (r.new_bound == BOUND_ALT) ? BOUND_UPPER : r.new_bound;
		fresh.move = (r.new_move_valid && r.new_move_index < CELLS) ?
			r.new_move_index : NO_MOVE;

		// Same key already held: refresh it, or refuse if it is worth more
		for (w = 0; w < ways; w++) begin
			s = b * WAYS + w;
			if (mirror_valid[b][w] && mirror_way[s].key == fresh.key) begin
				if (!evictable(mirror_way[s], fresh))
					return 1'b0;
				mirror_way[s] = fresh;
				return 1'b1;
			end
		end

		// Take the first free way
		for (w = 0; w < ways; w++) begin
			if (!mirror_valid[b][w]) begin
				mirror_way[b * WAYS + w] = fresh;
				mirror_valid[b][w] = 1'b1;
				mirror_count++;
				return 1'b1;
			end
		end

		// Bucket full: pick a victim among the eligible ways
		w0 = mirror_way[b * WAYS];
		w1 = mirror_way[b * WAYS + 1];
		e0 = evictable(w0, fresh);
		e1 = (ways == WAYS) && evictable(w1, fresh);
		if (!e0 && !e1)
			return 1'b0;
		victim = e0 ? 0 : 1;
		if (e0 && e1) begin
			if (w0.depth != w1.depth) begin
				victim = (w0.depth < w1.depth) ? 0 : 1;
			end else if (w0.bound != w1.bound &&
					(w0.bound == BOUND_EXACT || w1.bound == BOUND_EXACT)) begin
				victim = (w0.bound == BOUND_EXACT) ? 1 : 0;
			end else begin
				victim = 32'(mirror_toggle[b]);
				mirror_toggle[b] = ~mirror_toggle[b];
			end
		end
		mirror_way[b * WAYS + victim] = fresh;
		return 1'b1;
	endfunction

	// Work out the reply to one request and advance the mirror past it
	function automatic rsp_t table_reply(req_t r);
		rsp_t o;
		int unsigned b, ways, w, s;
		bit hit;
		o = '0;
		b = mirror_single ? 0 : (r.bucket_hash & (BUCKETS - 1));
		ways = mirror_single ? 1 : WAYS;
		case (r.cmd)
			CMD_STORE: begin
				if (mirror_enabled)
					o.success = store_entry(b, ways, r);
			end
			CMD_PROBE: begin
				hit = 1'b0;
				for (w = 0; w < ways && mirror_enabled && !hit; w++) begin
					s = b * WAYS + w;
					if (mirror_valid[b][w] && mirror_way[s].key == r.position_key) begin
						hit = 1'b1;
						o.success = 1'b1;
						o.found_score = mirror_way[s].score;
						o.found_depth = mirror_way[s].depth;
						o.found_bound = mirror_way[s].bound;
						if (mirror_way[s].move < CELLS) begin
							o.found_move_valid = 1'b1;
							o.found_move_index = mirror_way[s].move;
						end
					end
				end
			end
			CMD_CLEAR: begin
				// Clear empties everything, enabled or not
				for (w = 0; w < BUCKETS; w++) begin
					mirror_valid[w] = '0;
					mirror_toggle[w] = 1'b0;
				end
				mirror_count = 0;
				o.success = 1'b1;
			end
			default: ;
		endcase
		o.occupied_count = COUNT_W'(mirror_count);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic req_t mk_req(logic [1:0] cmd, logic [KEY_W-1:0] key,
			logic [HASH_W-1:0] hash, logic [15:0] score, logic [15:0] depth,
			logic [1:0] bnd, logic mv, logic [7:0] mi);
		req_t r;
		r.cmd = cmd;
		r.position_key = key;
		r.bucket_hash = hash;
		r.new_score = score;
		r.new_depth = depth;
		r.new_bound = bnd;
		r.new_move_valid = mv;
		r.new_move_index = mi;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned roll, k;
		// Clears are rare: each one costs a full sweep of the buckets
		roll = $urandom_range(0, 199);
		if (roll < 2)
			r.cmd = CMD_CLEAR;
		else if (roll < 8)
			r.cmd = CMD_UNUSED;
		else if (roll < 110)
			r.cmd = CMD_STORE;
		else
			r.cmd = CMD_PROBE;
		k = $urandom_range(0, POOL - 1);
		if ($urandom_range(0, 99) < 85) begin
			r.position_key = pool_key[k];
			r.bucket_hash = pool_hash[k];
		end else begin
			r.position_key = {$urandom, $urandom};
			r.bucket_hash = HASH_W'($urandom_range(0, BUCKETS - 1));
		end
		r.new_score = 16'($urandom);
		// Keep depths close so that ties and refusals are common
		roll = $urandom_range(0, 9);
		if (roll < 7)
			r.new_depth = 16'($urandom_range(0, 6));
		else if (roll < 9)
			r.new_depth = 16'($urandom);
		else
			r.new_depth = 16'($urandom_range(250, 260));
		r.new_bound = 2'($urandom_range(0, 3));
		r.new_move_valid = 1'($urandom_range(0, 1));
		r.new_move_index = ($urandom_range(0, 3) == 0) ?
			8'($urandom_range(CELLS, 255)) : 8'($urandom_range(0, CELLS - 1));
		return r;
	endfunction

	// Offer one request, hold it until taken, then log its predicted reply
	task automatic send_request(input req_t r);
		int unsigned gap;
		gap = (tx_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		replies_due.push_back(table_reply(r));
	endtask

	// Drop the request line and hold until every owed reply is back
	task automatic wait_for_replies();
		req_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic value);
		wait_for_replies();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_TABLE_ENABLED)
			mirror_enabled = value;
		else
			mirror_single = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_cases();
		logic [KEY_W-1:0] top_key;
		top_key = '1;
		// Empty table misses
		send_request(mk_req(CMD_PROBE, top_key, 12'hFFF, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		// Extreme score and depth; depth clamps to 255, last legal move cell
		send_request(mk_req(CMD_STORE, top_key, 12'hFFF, 16'h8000, 16'h7FFF, BOUND_EXACT,
			1'b1, 8'(CELLS - 1)));
		send_request(mk_req(CMD_PROBE, top_key, 12'hFFF, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		// Negative depth clamps to zero, bound three reads as upper,
		// a move index at the cell count is dropped
		send_request(mk_req(CMD_STORE, 64'd0, 12'h000, 16'h7FFF, 16'h8000, BOUND_ALT,
			1'b1, 8'(CELLS)));
		send_request(mk_req(CMD_PROBE, 64'd0, 12'h000, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		// Equal depth, stored entry not exact: update; no move flag
		send_request(mk_req(CMD_STORE, 64'd0, 12'h000, 16'd11, 16'd0, BOUND_EXACT, 1'b0, 8'd5));
		// Equal depth, stored exact, new lower bound: refused
		send_request(mk_req(CMD_STORE, 64'd0, 12'h000, 16'd12, 16'hFFFF, BOUND_LOWER, 1'b1, 8'd7));
		// Fill the second way, then evict the only eligible way
		send_request(mk_req(CMD_STORE, 64'd1, 12'h000, 16'd13, 16'd3, BOUND_LOWER, 1'b1, 8'd1));
		send_request(mk_req(CMD_STORE, 64'd2, 12'h000, 16'd14, 16'd2, BOUND_LOWER, 1'b1, 8'd2));
		send_request(mk_req(CMD_PROBE, 64'd0, 12'h000, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		// Both eligible, depths differ: take the shallower
		send_request(mk_req(CMD_STORE, 64'd3, 12'h000, 16'd15, 16'd3, BOUND_LOWER, 1'b1, 8'd3));
		// Both equal and non-exact: the toggle decides
		send_request(mk_req(CMD_STORE, 64'd4, 12'h000, 16'd16, 16'd3, BOUND_EXACT, 1'b1, 8'd4));
		// One exact, one not: replace the non-exact one
		send_request(mk_req(CMD_STORE, 64'd5, 12'h000, 16'd17, 16'd3, BOUND_EXACT, 1'b1, 8'd5));
		// Both exact and equal: toggle again
		send_request(mk_req(CMD_STORE, 64'd6, 12'h000, 16'd18, 16'd3, BOUND_EXACT, 1'b1, 8'd6));
		// Nothing eligible, and a shallower store on a held key: both refused
		send_request(mk_req(CMD_STORE, 64'd7, 12'h000, 16'd19, 16'd1, BOUND_LOWER, 1'b1, 8'd7));
		send_request(mk_req(CMD_STORE, 64'd6, 12'h000, 16'd20, 16'd2, BOUND_EXACT, 1'b1, 8'd8));
		send_request(mk_req(CMD_PROBE, 64'd6, 12'h000, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		send_request(mk_req(CMD_PROBE, 64'd4, 12'h000, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		// Unused command code changes nothing
		send_request(mk_req(CMD_UNUSED, 64'd6, 12'h000, 16'hFFFF, 16'd9, BOUND_ALT, 1'b1, 8'd9));
		send_request(mk_req(CMD_CLEAR, top_key, 12'hFFF, 16'hFFFF, 16'hFFFF, BOUND_ALT,
			1'b1, 8'hFF));
		send_request(mk_req(CMD_PROBE, 64'd6, 12'h000, 16'h0, 16'h0, BOUND_EXACT, 1'b0, 8'd0));
		send_request(mk_req(CMD_STORE, 64'd6, 12'h000, 16'd21, 16'd256, BOUND_UPPER, 1'b1, 8'd0));
	endtask

	task automatic test_random_two_way(input int unsigned count, input bit idling);
		tx_idle = idling;
		rx_idle = idling;
		repeat (count) send_request(random_request());
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Hold replies off for a long stretch while requests keep coming, so the
	// block backs up and stalls its input; then pause until it has drained.
	task automatic test_receiver_hold_off();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_cycles = 300;
		repeat (40) send_request(random_request());
		wait_for_replies();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Squeeze everything into one way, then return to two ways: entries held
	// before and during the switch must still be found.
	task automatic test_single_way_mode();
		write_register(CFG_SINGLE_WAY, 1'b1);
		repeat (100) send_request(random_request());
		write_register(CFG_SINGLE_WAY, 1'b0);
		repeat (40) send_request(random_request());
	endtask

	// Disabled table refuses stores and misses probes; a clear still wipes it
	task automatic test_disabled_table();
		req_t r;
		write_register(CFG_TABLE_ENABLED, 1'b0);
		repeat (25) send_request(random_request());
		r = random_request();
		r.cmd = CMD_CLEAR;
		send_request(r);
		repeat (25) send_request(random_request());
		write_register(CFG_TABLE_ENABLED, 1'b1);
		repeat (30) send_request(random_request());
	endtask

	// ------------------------------------------------------------------
	// Reply side: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin : reply_side
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				rsp_stall <= 1'b1;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
				rsp_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				repeat (idle_len()) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic string reply_text(rsp_t p);
		return $sformatf("ok=%0b score=%0d depth=%0d bound=%0d move=%0b/%0d count=%0d",
			p.success, p.found_score, p.found_depth, p.found_bound,
			p.found_move_valid, p.found_move_index, p.occupied_count);
	endfunction

	// Check each reply taken from the block against the oldest prediction
	always @(posedge clk) begin : reply_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (replies_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: reply with none owed: %s", $time, reply_text(rsp_data));
			end else begin
				want = replies_due.pop_front();
				if (want.success !== rsp_data.success ||
						want.found_score !== rsp_data.found_score ||
						want.found_depth !== rsp_data.found_depth ||
						want.found_bound !== rsp_data.found_bound ||
						want.found_move_valid !== rsp_data.found_move_valid ||
						want.found_move_index !== rsp_data.found_move_index ||
						want.occupied_count !== rsp_data.occupied_count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: reply mismatch\n  expected %s\n  actual   %s",
							$time, reply_text(want), reply_text(rsp_data));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : run
		logic [HASH_W-1:0] hot [4];
		int i;
		// Four busy buckets, the two end buckets among them
		hot[0] = '0;
		hot[1] = '1;
		hot[2] = HASH_W'($urandom_range(1, BUCKETS - 2));
		hot[3] = HASH_W'($urandom_range(1, BUCKETS - 2));
		for (i = 0; i < POOL; i++) begin
			pool_key[i] = {$urandom, $urandom};
			pool_hash[i] = hot[i % 4];
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(CFG_TABLE_ENABLED, 1'b1);
		write_register(CFG_SINGLE_WAY, 1'b0);
		test_directed_cases();
		test_random_two_way(450, 1'b1);
		test_random_two_way(120, 1'b0);
		test_receiver_hold_off();
		test_single_way_mode();
		test_disabled_table();
		wait_for_replies();

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Give up long after the slowest correct run would have ended
	initial begin : watchdog
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
